// ----- sv/dcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types and constants for the depthwise causal conv1d step unit.
// ----------------------------------------------------------------------------
package dcc_pkg;

    localparam int DATA_W  = 16;
    localparam int CH_W    = 12;
    localparam int TAP_W   = 2;
    localparam int OP_W    = 1;
    localparam int FRAC_W  = 4;
    localparam int PROD_W  = 2 * DATA_W;

    localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd14;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_FILTER = 1'b0,
        OP_LOAD   = 1'b1
    } dcc_op_t;

    // One classified word as it travels from front to back.
    typedef struct packed {
        dcc_op_t                  op;
        logic [CH_W-1:0]          ch;
        logic [TAP_W-1:0]         tap;
        logic signed [DATA_W-1:0] data;
    } dcc_item_t;

endpackage

// ----- sv/dcc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_front
// Input stage: accepts words, drops out-of-range channels and taps, and
// hands the rest to the queue.
// ----------------------------------------------------------------------------
module dcc_front #(
    parameter int CHANNELS = 4096,
    parameter int TAPS     = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dcc_pkg::OP_W-1:0]            opcode,
    input  logic [dcc_pkg::CH_W-1:0]            channel_index,
    input  logic [dcc_pkg::TAP_W-1:0]           tap_index,
    input  logic signed [dcc_pkg::DATA_W-1:0]   sample_value,
    input  logic signed [dcc_pkg::DATA_W-1:0]   weight_value,
    input  logic                                busy,
    input  logic                                q_full,
    output logic                                push,
    output dcc_pkg::dcc_item_t                  push_item
);

    import dcc_pkg::*;

    logic      f_valid_reg;
    logic      f_valid_next;
    dcc_item_t f_item_reg;
    dcc_item_t f_item_next;
    logic      room;
    logic      take;
    logic      keep;

    assign room      = !f_valid_reg || !q_full;
    assign in_stall  = busy || !room;
    assign take      = in_valid && !in_stall;
    assign push      = f_valid_reg && !q_full;
    assign push_item = f_item_reg;

    always_comb
    begin
        f_item_next.op   = dcc_op_t'(opcode);
        f_item_next.ch   = channel_index;
        f_item_next.tap  = tap_index;
        f_item_next.data = (dcc_op_t'(opcode) == OP_FILTER) ? sample_value : weight_value;

        keep = (32'(channel_index) < 32'(CHANNELS)) &&
               ((dcc_op_t'(opcode) == OP_FILTER) || (32'(tap_index) < 32'(TAPS)));

        f_valid_next = f_valid_reg;
        if (take)
        begin
            // drop words that touch no state
            f_valid_next = keep;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

// ----- sv/dcc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_queue
// Short FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module dcc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dcc_pkg::dcc_item_t push_item,
    output logic               full,
    input  logic               pop,
    output dcc_pkg::dcc_item_t head_item,
    output logic               empty
);

    import dcc_pkg::*;

    dcc_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/dcc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_back
// Execution side: weight and history stores, multiply, sum, round and
// saturate, with an output register toward the consumer.
// ----------------------------------------------------------------------------
module dcc_back #(
    parameter int CHANNELS = 4096,
    parameter int TAPS     = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [dcc_pkg::FRAC_W-1:0]          cfg_data,
    input  dcc_pkg::dcc_item_t                  head_item,
    input  logic                                q_empty,
    output logic                                pop,
    output logic                                busy,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dcc_pkg::CH_W-1:0]            out_channel,
    output logic signed [dcc_pkg::DATA_W-1:0]   filtered_value,
    output logic                                saturated
);

    import dcc_pkg::*;

    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_LEN = TAPS - 1;
    localparam int HIST_W   = DATA_W * HIST_LEN;
    localparam int WROW_W   = DATA_W * TAPS;
    localparam int SUM_W    = PROD_W + $clog2(TAPS);

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);
    localparam logic [CH_AW-1:0]        LAST_CH = CH_AW'(CHANNELS - 1);

    // stores
    logic [HIST_W-1:0] hist_mem [CHANNELS];
    logic [WROW_W-1:0] wt_mem   [CHANNELS];

    // configuration
    logic [FRAC_W-1:0] cfg_f_reg;
    logic [FRAC_W-1:0] cfg_f_next;

    // clearing pass
    logic              clr_active_reg;
    logic              clr_active_next;
    logic [CH_AW-1:0]  clr_addr_reg;
    logic [CH_AW-1:0]  clr_addr_next;

    // pop side
    logic [CH_AW-1:0]  head_addr;
    logic              rd_en;
    logic              wt_we;

    // stage 1: read data and operands
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CH_W-1:0]   s1_ch_reg;
    logic [CH_AW-1:0]  s1_addr_reg;
    logic signed [DATA_W-1:0] s1_sample_reg;
    logic [HIST_W-1:0] hist_rd_reg;
    logic [WROW_W-1:0] wt_rd_reg;
    logic [HIST_W-1:0] hist_eff;
    logic [HIST_W-1:0] hist_new;
    logic [WROW_W-1:0] tap_row;
    logic signed [PROD_W-1:0] prod [TAPS];

    // last history row written, for back-to-back words on one channel
    logic              fwd_valid_reg;
    logic              fwd_valid_next;
    logic [CH_AW-1:0]  fwd_addr_reg;
    logic [HIST_W-1:0] fwd_row_reg;

    // stage 2: products
    logic              s2_valid_reg;
    logic              s2_valid_next;
    logic [CH_W-1:0]   s2_ch_reg;
    logic signed [PROD_W-1:0] s2_prod_reg [TAPS];
    logic signed [SUM_W-1:0]  bias;

    // stage 3: rounded sum
    logic              s3_valid_reg;
    logic              s3_valid_next;
    logic [CH_W-1:0]   s3_ch_reg;
    logic signed [SUM_W-1:0] s3_sum_reg;
    logic signed [SUM_W-1:0] s3_sum_next;
    logic signed [SUM_W-1:0] shifted;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CH_W-1:0]   out_channel_reg;
    logic signed [DATA_W-1:0] filtered_value_reg;
    logic signed [DATA_W-1:0] result_next;
    logic              saturated_reg;
    logic              sat_next;

    logic free_out;
    logic free3;
    logic free2;
    logic free1;
    logic adv1;

    // pipeline flow
    assign free_out = !out_valid_reg || !out_stall;
    assign free3    = !s3_valid_reg || free_out;
    assign free2    = !s2_valid_reg || free3;
    assign free1    = !s1_valid_reg || free2;
    assign adv1     = s1_valid_reg && free2;

    assign head_addr = CH_AW'(head_item.ch);
    assign pop       = !q_empty && !clr_active_reg &&
                       ((head_item.op == OP_LOAD) || free1);
    assign rd_en     = pop && (head_item.op == OP_FILTER);
    assign wt_we     = pop && (head_item.op == OP_LOAD);
    assign busy      = clr_active_reg;

    assign out_valid      = out_valid_reg;
    assign out_channel    = out_channel_reg;
    assign filtered_value = filtered_value_reg;
    assign saturated      = saturated_reg;

    // ---------------- control next state ----------------
    always_comb
    begin
        cfg_f_next = cfg_write ? cfg_data : cfg_f_reg;

        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next   = clr_addr_reg + 1'b1;
            clr_active_next = (clr_addr_reg != LAST_CH);
        end

        s1_valid_next  = free1 ? rd_en : s1_valid_reg;
        s2_valid_next  = free2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = free3 ? s2_valid_reg : s3_valid_reg;
        out_valid_next = free_out ? s3_valid_reg : out_valid_reg;
        fwd_valid_next = fwd_valid_reg || adv1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_f_reg      <= FRAC_RESET;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            cfg_f_reg      <= cfg_f_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            s3_valid_reg   <= s3_valid_next;
            out_valid_reg  <= out_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
        end
    end

    // ---------------- stores ----------------
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            hist_mem[clr_addr_reg] <= '0;
        end
        else if (adv1)
        begin
            hist_mem[s1_addr_reg] <= hist_new;
        end
        if (rd_en)
        begin
            hist_rd_reg <= hist_mem[head_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < TAPS; t++)
        begin
            if (wt_we && (32'(head_item.tap) == t))
            begin
                wt_mem[head_addr][t*DATA_W +: DATA_W] <= head_item.data;
            end
        end
        if (rd_en)
        begin
            wt_rd_reg <= wt_mem[head_addr];
        end
    end

    // ---------------- stage 1 ----------------
    always_comb
    begin
        // a write from the word just ahead lands on the edge of our read
        hist_eff = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_row_reg : hist_rd_reg;

        // oldest sample sits at the low end of the row
        for (int k = 0; k < HIST_LEN - 1; k++)
        begin
            hist_new[k*DATA_W +: DATA_W] = hist_eff[(k+1)*DATA_W +: DATA_W];
        end
        hist_new[(HIST_LEN-1)*DATA_W +: DATA_W] = s1_sample_reg;

        tap_row = {s1_sample_reg, hist_eff};
        for (int k = 0; k < TAPS; k++)
        begin
            prod[k] = $signed(tap_row[k*DATA_W +: DATA_W]) *
                      $signed(wt_rd_reg[k*DATA_W +: DATA_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_ch_reg     <= head_item.ch;
            s1_addr_reg   <= head_addr;
            s1_sample_reg <= head_item.data;
        end
        if (adv1)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_row_reg  <= hist_new;
            s2_ch_reg    <= s1_ch_reg;
            for (int k = 0; k < TAPS; k++)
            begin
                s2_prod_reg[k] <= prod[k];
            end
        end
    end

    // ---------------- stage 2 ----------------
    always_comb
    begin
        // rounding bias folds into the sum
        bias = (cfg_f_reg == '0) ? '0 : (SUM_W'(1) << (cfg_f_reg - 1'b1));
        s3_sum_next = bias;
        for (int k = 0; k < TAPS; k++)
        begin
            s3_sum_next = s3_sum_next + SUM_W'(s2_prod_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && free3)
        begin
            s3_ch_reg  <= s2_ch_reg;
            s3_sum_reg <= s3_sum_next;
        end
    end

    // ---------------- stage 3 ----------------
    always_comb
    begin
        shifted = s3_sum_reg >>> cfg_f_reg;
        if (shifted > SAT_HI)
        begin
            result_next = 16'sh7fff;
            sat_next    = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            result_next = 16'sh8000;
            sat_next    = 1'b1;
        end
        else
        begin
            result_next = shifted[DATA_W-1:0];
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && free_out)
        begin
            out_channel_reg    <= s3_ch_reg;
            filtered_value_reg <= result_next;
            saturated_reg      <= sat_next;
        end
    end

endmodule

// ----- sv/depthwise_causal_conv1d_step_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depthwise_causal_conv1d_step_unit
// Per-channel causal FIR decode step with weight load and rounded output.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while out_stall and the clearing pass hold
//   nothing back; the history store's read-then-write path forwards the last
//   written row, so one channel may repeat every cycle.
// Reset: history store is zeroed by a pass over all CHANNELS rows with in_stall
//   high; weights are undefined until loaded; cfg_f_reg resets to 14.
// ----------------------------------------------------------------------------
module depthwise_causal_conv1d_step_unit #(
    parameter int CHANNELS = 4096,
    parameter int TAPS     = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [dcc_pkg::FRAC_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dcc_pkg::OP_W-1:0]            opcode,
    input  logic [dcc_pkg::CH_W-1:0]            channel_index,
    input  logic [dcc_pkg::TAP_W-1:0]           tap_index,
    input  logic signed [dcc_pkg::DATA_W-1:0]   sample_value,
    input  logic signed [dcc_pkg::DATA_W-1:0]   weight_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dcc_pkg::CH_W-1:0]            out_channel,
    output logic signed [dcc_pkg::DATA_W-1:0]   filtered_value,
    output logic                                saturated
);

    import dcc_pkg::*;

    logic      busy;
    logic      push;
    logic      q_full;
    logic      q_empty;
    logic      pop;
    dcc_item_t push_item;
    dcc_item_t head_item;

    dcc_front #(
        .CHANNELS (CHANNELS),
        .TAPS     (TAPS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .channel_index (channel_index),
        .tap_index     (tap_index),
        .sample_value  (sample_value),
        .weight_value  (weight_value),
        .busy          (busy),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    dcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    dcc_back #(
        .CHANNELS (CHANNELS),
        .TAPS     (TAPS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .head_item      (head_item),
        .q_empty        (q_empty),
        .pop            (pop),
        .busy           (busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_channel    (out_channel),
        .filtered_value (filtered_value),
        .saturated      (saturated)
    );

endmodule

// ----- sv/dcc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_port_checker
// Port-level checks for the conv1d step unit, bound to the top level.
// ----------------------------------------------------------------------------
module dcc_port_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [dcc_pkg::CH_W-1:0]            out_channel,
    input logic signed [dcc_pkg::DATA_W-1:0]   filtered_value,
    input logic                                saturated
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_channel) &&
        $stable(filtered_value) && $stable(saturated))
        else $error("result word changed while stalled");

    // a clipped result sits at one rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> filtered_value == 16'sh7fff ||
        filtered_value == 16'sh8000)
        else $error("saturated flag without rail value");

    // the clearing pass holds off input right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall && !out_valid)
        else $error("input taken before history clear");

endmodule

bind depthwise_causal_conv1d_step_unit dcc_port_checker u_dcc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .filtered_value (filtered_value),
    .saturated      (saturated)
);
